FILE: rtl/core/bss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants for the bounded set store.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned CNT_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_ABSENT  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

  typedef struct packed {
    logic             cmp_en;
    logic             shift_en;
    logic             add_en;
    logic [VAL_W-1:0] key;
  } cell_ctl_t;

endpackage

FILE: rtl/core/bounded_set_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_set_store_unit
// The cell chain compares a word as it is accepted and acts on it in the
// evaluate state, which loads the result; no new word is taken in that state.
// The result register lets the next word in as the current result is taken.
// Reset (rst_n, synchronous): count cleared, capacity limit set to 16,
// store contents left undefined.
// ----------------------------------------------------------------------------
module bounded_set_store_unit #(
  parameter int unsigned DEPTH = bss_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // elem_value[31:0]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // position[3:0], count[8:4], full_flag[9],
                                  // empty_flag[10], zero pad[15:11]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);
  import bss_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;

  state_t            state_r;
  state_t            state_nxt;
  logic [OP_W-1:0]   op_r;
  logic [VAL_W-1:0]  key_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic              out_valid_r;
  logic [15:0]       out_tdata_r;
  logic [1:0]        out_tuser_r;

  logic              in_acc;
  logic              eval;
  logic              hit;
  logic [IW-1:0]     slot;
  logic [LW-1:0]     lim;
  logic              at_lim;
  cell_ctl_t         ctl;
  status_t           status;
  logic [IW-1:0]     pos;
  logic [DEPTH-1:0]  match;
  logic [DEPTH:0]    shift_c;
  logic [VAL_W-1:0]  vals [DEPTH];
  logic [31:0]       pos_ext;
  logic [31:0]       cnt_ext;

  assign cfg_ready  = 1'b1;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign lim    = (LW'(cap_r) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap_r);
  assign at_lim = LW'(count_r) >= lim;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    eval      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = !out_valid_r || out_tready;
      end
      S_EVAL: begin
        eval = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // operation decode
  always_comb begin
    status       = ST_DONE;
    pos          = '0;
    count_nxt    = count_r;
    ctl.cmp_en   = in_acc;
    ctl.shift_en = 1'b0;
    ctl.add_en   = 1'b0;
    ctl.key      = eval ? key_r : in_tdata;
    if (eval) begin
      case (op_r)
        OP_ADD: begin
          if (hit) begin
            status = ST_PRESENT;
            pos    = slot;
          end else if (at_lim) begin
            status = ST_FULL;
          end else begin
            ctl.add_en = 1'b1;
            pos        = IW'(count_r);
            count_nxt  = count_r + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            ctl.shift_en = 1'b1;
            pos          = slot;
            count_nxt    = count_r - 1'b1;
          end else begin
            status = ST_ABSENT;
          end
        end
        OP_SEARCH: begin
          if (hit) begin
            pos = slot;
          end else begin
            status = ST_ABSENT;
          end
        end
        default: begin
          status = ST_DONE;
        end
      endcase
    end
  end

  assign pos_ext = 32'(pos);
  assign cnt_ext = 32'(count_nxt);

  assign shift_c[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = vals[i];
    end else begin : g_mid
      assign nbr = vals[i+1];
    end
    bss_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .count     (count_r),
      .nbr_val   (nbr),
      .shift_in  (shift_c[i]),
      .shift_out (shift_c[i+1]),
      .match     (match[i]),
      .val       (vals[i])
    );
  end

  bss_encode #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_encode (
    .match (match),
    .hit   (hit),
    .slot  (slot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (eval) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tuser;
      key_r <= in_tdata;
    end
    if (eval) begin
      out_tuser_r <= status;
      out_tdata_r <= {5'd0,
                      (count_nxt == '0),
                      (LW'(count_nxt) >= lim),
                      cnt_ext[CNT_W-1:0],
                      pos_ext[POS_W-1:0]};
    end
  end

endmodule

FILE: rtl/core/bss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_cell
// One slot of the store: holds a value, registers its key match and takes
// its upper neighbour's value on a remove at or below this slot.
// ----------------------------------------------------------------------------
module bss_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CW    = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bss_pkg::cell_ctl_t       ctl,
  input  logic [CW-1:0]            count,
  input  logic [bss_pkg::VAL_W-1:0] nbr_val,
  input  logic                     shift_in,
  output logic                     shift_out,
  output logic                     match,
  output logic [bss_pkg::VAL_W-1:0] val
);
  import bss_pkg::*;

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;
  logic             match_r;
  logic             match_nxt;
  logic             occupied;

  assign occupied  = CW'(IDX) < count;
  assign shift_out = shift_in | match_r;
  assign match     = match_r;
  assign val       = val_r;

  always_comb begin
    match_nxt = match_r;
    if (ctl.cmp_en) begin
      match_nxt = occupied && (val_r == ctl.key);
    end
  end

  always_comb begin
    val_nxt = val_r;
    if (ctl.shift_en && shift_out) begin
      val_nxt = nbr_val;
    end else if (ctl.add_en && (CW'(IDX) == count)) begin
      val_nxt = ctl.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

FILE: rtl/core/bss_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_encode
// Turns the one-hot match row of the cell chain into a hit flag and a slot.
// ----------------------------------------------------------------------------
module bss_encode #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW    = 4
) (
  input  logic [DEPTH-1:0] match,
  output logic             hit,
  output logic [IW-1:0]    slot
);

  assign hit = |match;

  // held values are distinct, so at most one bit is set
  always_comb begin
    slot = '0;
    for (int i = 0; i < DEPTH; i++) begin
      slot = slot | (IW'(i) & {IW{match[i]}});
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stand-alone bench for bounded_set_store_unit. A queue of request words and
// capacity writes feeds a clocked driver; a clocked monitor checks every
// result word against a predicted set held in the bench. A directed burst
// comes first, then random phases over several capacity limits with sender
// gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import bss_pkg::*;

  localparam int unsigned SLOTS          = DEPTH_DEF;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          TAIL_CYCLES    = 8;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          REPORT_MAX     = 10;
  localparam int          PHASE_WORDS    = 60;

  typedef struct {
    logic        is_cfg;
    logic [1:0]  op;
    logic [31:0] value;
    logic [4:0]  cap;
    int          gap_pct;
    int          stall_pct;
  } stim_word_t;

  typedef struct {
    status_t    status;
    logic [3:0] position;
    logic [4:0] count;
    logic       full;
    logic       empty;
  } set_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;  // elem_value[31:0]
  logic [1:0]  in_tuser   = '0;  // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // position[3:0], count[8:4], full_flag[9], empty_flag[10]
  logic [1:0]  out_tuser;        // status[1:0]
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data   = '0;

  stim_word_t  pending_words[$];
  set_result_t expected_results[$];

  logic [31:0] set_slots [SLOTS];
  int unsigned set_count = 0;
  logic [4:0]  set_cap   = CAP_RESET;

  logic        in_taken   = 1'b0;
  logic        cfg_taken  = 1'b0;
  int          settle_cnt = 0;
  int          cur_gap    = 0;
  int          cur_stall  = 0;
  int          idle_cycles = 0;
  int          err_count  = 0;

  bounded_set_store_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic predict_set_op(input logic [1:0] op, input logic [31:0] value);
    set_result_t r;
    int unsigned limit;
    int unsigned slot;
    logic        hit;
    limit = (set_cap > SLOTS) ? SLOTS : set_cap;
    hit   = 1'b0;
    slot  = 0;
    for (int unsigned i = 0; i < set_count; i++) begin
      if (!hit && set_slots[i] == value) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    r.status   = ST_DONE;
    r.position = '0;
    if (op == OP_ADD) begin
      if (hit) begin
        r.status   = ST_PRESENT;
        r.position = slot[3:0];
      end else if (set_count >= limit) begin
        r.status = ST_FULL;
      end else begin
        set_slots[set_count] = value;
        r.position = set_count[3:0];
        set_count++;
      end
    end else if (op == OP_REMOVE) begin
      if (hit) begin
        for (int unsigned i = slot; i + 1 < set_count; i++)
          set_slots[i] = set_slots[i + 1];
        set_count--;
        r.position = slot[3:0];
      end else begin
        r.status = ST_ABSENT;
      end
    end else if (op == OP_SEARCH) begin
      if (hit)
        r.position = slot[3:0];
      else
        r.status = ST_ABSENT;
    end
    r.count = set_count[4:0];
    r.full  = (set_count >= limit);
    r.empty = (set_count == 0);
    expected_results.push_back(r);
  endtask

  task automatic queue_request(input logic [1:0] op, input logic [31:0] value,
                               input int gap, input int stall);
    stim_word_t w;
    w.is_cfg    = 1'b0;
    w.op        = op;
    w.value     = value;
    w.cap       = '0;
    w.gap_pct   = gap;
    w.stall_pct = stall;
    pending_words.push_back(w);
  endtask

  task automatic queue_cap(input logic [4:0] cap);
    stim_word_t w;
    w.is_cfg    = 1'b1;
    w.op        = OP_UNUSED;
    w.value     = '0;
    w.cap       = cap;
    w.gap_pct   = 0;
    w.stall_pct = 0;
    pending_words.push_back(w);
  endtask

  // driver
  always @(negedge clk) begin
    logic        drv_valid;
    logic [1:0]  drv_op;
    logic [31:0] drv_value;
    logic        drv_cfg;
    logic [4:0]  drv_cap;
    logic        drv_ready;
    stim_word_t  head;
    drv_valid = in_tvalid;
    drv_op    = in_tuser;
    drv_value = in_tdata;
    drv_cfg   = cfg_valid;
    drv_cap   = cfg_data;
    drv_ready = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_taken) drv_valid = 1'b0;
      if (cfg_valid && cfg_taken) drv_cfg = 1'b0;
      if (!drv_valid && !drv_cfg && pending_words.size() > 0) begin
        head = pending_words[0];
        if (head.is_cfg) begin
          // capacity only changes once every result is home and the pipe has drained
          if (expected_results.size() == 0 && !in_tvalid) begin
            if (settle_cnt >= SETTLE_CYCLES) begin
              drv_cfg = 1'b1;
              drv_cap = head.cap;
              void'(pending_words.pop_front());
              settle_cnt = 0;
            end else begin
              settle_cnt++;
            end
          end else begin
            settle_cnt = 0;
          end
        end else begin
          cur_gap   = head.gap_pct;
          cur_stall = head.stall_pct;
          if ($urandom_range(99) >= cur_gap) begin
            drv_valid = 1'b1;
            drv_op    = head.op;
            drv_value = head.value;
            void'(pending_words.pop_front());
          end
        end
      end
      drv_ready = ($urandom_range(99) >= cur_stall);
    end
    in_taken  = 1'b0;
    cfg_taken = 1'b0;
    in_tvalid  <= drv_valid;
    in_tuser   <= drv_op;
    in_tdata   <= drv_value;
    cfg_valid  <= drv_cfg;
    cfg_data   <= drv_cap;
    out_tready <= drv_ready;
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    set_result_t exp_r;
    logic [3:0]  got_pos;
    logic [4:0]  got_count;
    logic        got_full;
    logic        got_empty;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_pos   = out_tdata[3:0];
        got_count = out_tdata[8:4];
        got_full  = out_tdata[9];
        got_empty = out_tdata[10];
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display("unexpected result word: status %0d pos %0d count %0d full %0b empty %0b",
                     out_tuser, got_pos, got_count, got_full, got_empty);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tuser !== exp_r.status || got_pos !== exp_r.position ||
              got_count !== exp_r.count || got_full !== exp_r.full ||
              got_empty !== exp_r.empty) begin
            err_count++;
            if (err_count <= REPORT_MAX)
              $display("mismatch: expected status %0d pos %0d count %0d full %0b empty %0b, got status %0d pos %0d count %0d full %0b empty %0b",
                       exp_r.status, exp_r.position, exp_r.count, exp_r.full, exp_r.empty,
                       out_tuser, got_pos, got_count, got_full, got_empty);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_set_op(in_tuser, in_tdata);
        in_taken = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        set_cap   = cfg_data;
        cfg_taken = 1'b1;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL bounded_set_store_unit");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] pool [20];
    logic [4:0]  caps [8];
    logic [1:0]  op;
    logic [31:0] value;
    int          r;
    int          gap;
    int          stall;
    int          add_pct;
    int          rem_pct;

    caps = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd9, 5'd17, 5'd1, 5'd16};
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    pool[2] = 32'h8000_0000;
    pool[3] = 32'h7FFF_FFFF;
    pool[4] = 32'h0000_0001;
    for (int i = 5; i < 20; i++) pool[i] = $urandom;

    // empty set under the reset limit
    queue_request(OP_SEARCH, 32'h0000_0000, 0, 0);
    queue_request(OP_REMOVE, 32'h0000_0005, 0, 0);
    queue_request(OP_UNUSED, 32'hFFFF_FFFF, 0, 0);
    queue_cap(5'd6);
    queue_request(OP_ADD,    32'h8000_0000, 0, 0);
    queue_request(OP_ADD,    32'h7FFF_FFFF, 0, 0);
    queue_request(OP_ADD,    32'h0000_0000, 0, 0);
    queue_request(OP_ADD,    32'hFFFF_FFFF, 0, 0);
    queue_request(OP_ADD,    32'h7FFF_FFFF, 0, 0);
    queue_request(OP_SEARCH, 32'hFFFF_FFFF, 0, 0);
    queue_request(OP_REMOVE, 32'h8000_0000, 0, 0);
    queue_request(OP_SEARCH, 32'hFFFF_FFFF, 0, 0);
    queue_request(OP_REMOVE, 32'hFFFF_FFFF, 0, 0);
    for (int k = 0; k < 4; k++) queue_request(OP_ADD, 32'h1 << k, 0, 0);
    queue_request(OP_ADD,    32'h5A5A_A5A5, 0, 0);
    queue_request(OP_ADD,    32'h0000_0000, 0, 0);
    queue_request(OP_SEARCH, 32'h0000_0008, 0, 0);
    queue_request(OP_REMOVE, 32'h7FFF_FFFF, 0, 0);
    queue_request(OP_UNUSED, 32'h0000_0000, 0, 0);

    for (int c = 0; c < 8; c++) begin
      queue_cap(caps[c]);
      for (int m = 0; m < 4; m++) begin
        case (m)
          0: begin gap = 0;  stall = 0;  end
          1: begin gap = 56; stall = 0;  end
          2: begin gap = 0;  stall = 56; end
          default: begin gap = 30; stall = 30; end
        endcase
        // alternate between filling and draining the set
        if ((m + c) % 2 == 0) begin
          add_pct = 55;
          rem_pct = 20;
        end else begin
          add_pct = 30;
          rem_pct = 35;
        end
        for (int k = 0; k < PHASE_WORDS; k++) begin
          r = $urandom_range(99);
          if (r < add_pct)                op = OP_ADD;
          else if (r < add_pct + rem_pct) op = OP_REMOVE;
          else if (r < 95)                op = OP_SEARCH;
          else                            op = OP_UNUSED;
          if ($urandom_range(99) < 85) value = pool[$urandom_range(19)];
          else                         value = $urandom;
          queue_request(op, value, gap, stall);
        end
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_tvalid || cfg_valid ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0 && expected_results.size() == 0) begin
      $display("PASS bounded_set_store_unit");
    end else begin
      $display("FAIL bounded_set_store_unit");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/bss_pkg.sv
rtl/core/bss_cell.sv
rtl/core/bss_encode.sv
rtl/core/bounded_set_store_unit.sv
test/tb.sv
